### hw/rtl/fsg_pkg.sv
`default_nettype none

package fsg_pkg;

    // default width of the order and of every term field
    localparam int ORDER_BITS_DEF = 8;

    // order after reset
    localparam int MAX_ORDER_RST = 8;

endpackage

`default_nettype wire

### hw/rtl/fsg_divmul.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// The quotient bits also drive a Horner accumulator, so the product
// quotient * mul_c is ready together with the remainder.
module fsg_divmul #(
    parameter int W = fsg_pkg::ORDER_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W:0]     i_dividend,
    input  wire logic [W-1:0]   i_divisor,
    input  wire logic [W-1:0]   i_mul_c,
    output logic                o_done,
    output logic [W-1:0]        o_rem,
    output logic [2*W:0]        o_prod
);

    localparam int CW = $clog2(W + 2);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W:0]    r_dvd;
    logic [W-1:0]  r_d;
    logic [W-1:0]  r_c;
    logic [2*W:0]  r_prod;

    logic [W:0]    trial;
    logic [W-1:0]  diff;
    logic          ge;
    logic [W-1:0]  n_rem;
    logic [2*W:0]  n_prod;

    always_comb begin
        trial  = {r_rem, r_dvd[W]};
        // remainder stays below the divisor, so the low bits of the difference suffice
        diff   = trial[W-1:0] - r_d;
        ge     = (trial >= {1'b0, r_d});
        n_rem  = ge ? diff : trial[W-1:0];
        n_prod = {r_prod[2*W-1:0], 1'b0} + (ge ? {{(W+1){1'b0}}, r_c} : {(2*W+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_d    <= i_divisor;
            r_c    <= i_mul_c;
            r_prod <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[W-1:0], 1'b0};
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

### hw/rtl/farey_sequence_generator_top.sv
`default_nettype none

// Farey sequence generator: one term of the sequence of order max_order per request.
// Input channel (i_in_valid / o_in_stall) carries i_restart: 1 starts over at 0/1,
// 0 asks for the next term. Each request gives exactly one result on the output
// channel (o_out_valid / i_out_stall): o_numerator / o_denominator, o_last on 1/1.
// After 1/1 the next request wraps to 0/1. Order 0 acts as order 1.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes max_order; write it
// only while no request is in flight. The new order applies from the next request.
// A request for 0/1 or the first term 1/N goes from ST_IDLE straight to ST_FIN and
// then into the output register; a general term passes ST_DIV first, where the
// bit-serial divider computes floor((N + b) / d). The block takes a new request only
// once the previous one has left ST_FIN.
// One request is in the block at a time; a new request is taken while the previous
// result still waits at the output. If the receiver stalls, the result holds in
// the output register and the next finished term waits until it is taken.
// Reset (synchronous, active low): order 8, sequence state cleared, the first
// request after reset always returns 0/1.
module farey_sequence_generator_top #(
    parameter int ORDER_BITS = fsg_pkg::ORDER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_restart,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ORDER_BITS-1:0]      o_numerator,
    output logic [ORDER_BITS-1:0]      o_denominator,
    output logic                       o_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [ORDER_BITS-1:0] i_cfg_data
);

    localparam int W = ORDER_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]   r_state;
    logic         r_started;
    logic [W-1:0] r_max_order;
    logic [W-1:0] r_prev_num;
    logic [W-1:0] r_prev_den;
    logic [W-1:0] r_cur_num;
    logic [W-1:0] r_cur_den;
    logic         r_out_valid;
    logic [W-1:0] r_out_num;
    logic [W-1:0] r_out_den;
    logic         r_out_last;

    // pending term and the order latched at accept
    logic         r_go_start;
    logic [W-1:0] r_res_num;
    logic [W-1:0] r_res_den;
    logic [W-1:0] r_n;
    logic [W:0]   r_x;

    logic         in_acc;
    logic         out_free;
    logic         div_start;
    logic [W-1:0] n_ord;
    logic [W:0]   n_x;
    logic         is_start;

    logic         div_done;
    logic [W-1:0] div_rem;
    logic [2*W:0] kc;
    logic [W:0]   kd;
    logic [2*W:0] e;
    logic [W:0]   f;
    logic         bad;
    logic [W-1:0] n_res_num;
    logic [W-1:0] n_res_den;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_ord     = (r_max_order == '0) ? W'(1) : r_max_order;
        n_x       = {1'b0, n_ord} + {1'b0, r_prev_den};
        is_start  = i_restart || !r_started || (r_cur_den == '0) || (r_cur_num >= r_cur_den);
        div_start = in_acc && !is_start && (r_cur_num != '0);
    end

    fsg_divmul #(
        .W (W)
    ) u_divmul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_x),
        .i_divisor  (r_cur_den),
        .i_mul_c    (r_cur_num),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod     (kc)
    );

    // next = (k*c - a) / (k*d - b); falls back to 1/1 when that is no valid term
    always_comb begin
        kd  = r_x - {1'b0, div_rem};
        e   = kc - {{(W+1){1'b0}}, r_prev_num};
        f   = kd - {1'b0, r_prev_den};
        bad = (kd <= {1'b0, r_prev_den})
           || (kc < {{(W+1){1'b0}}, r_prev_num})
           || (e >= {{W{1'b0}}, f})
           || (f > {1'b0, r_n});
        n_res_num = bad ? W'(1) : e[W-1:0];
        n_res_den = bad ? W'(1) : f[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_max_order <= W'(fsg_pkg::MAX_ORDER_RST);
            r_prev_num  <= '0;
            r_prev_den  <= W'(1);
            r_cur_num   <= '0;
            r_cur_den   <= W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_order <= i_cfg_data;
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= div_start ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                        if (r_go_start) begin
                            r_started  <= 1'b1;
                            r_prev_num <= '0;
                            r_prev_den <= W'(1);
                        end else begin
                            r_prev_num <= r_cur_num;
                            r_prev_den <= r_cur_den;
                        end
                        r_cur_num <= r_res_num;
                        r_cur_den <= r_res_den;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_go_start <= is_start;
            r_n        <= n_ord;
            r_x        <= n_x;
            if (is_start) begin
                r_res_num <= '0;
                r_res_den <= W'(1);
            end else begin
                r_res_num <= W'(1);
                r_res_den <= n_ord;
            end
        end else if ((r_state == ST_DIV) && div_done) begin
            r_res_num <= n_res_num;
            r_res_den <= n_res_den;
        end
        if ((r_state == ST_FIN) && out_free) begin
            r_out_num  <= r_res_num;
            r_out_den  <= r_res_den;
            r_out_last <= (r_res_num == W'(1)) && (r_res_den == W'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_numerator   = r_out_num;
    assign o_denominator = r_out_den;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int W              = fsg_pkg::ORDER_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 44;

    typedef struct packed {
        logic [W-1:0] num;
        logic [W-1:0] den;
        logic         last;
    } t_farey_term;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         o_in_stall;
    logic         restart = 1'b0;
    logic         o_out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] o_numerator;
    logic [W-1:0] o_denominator;
    logic         o_last;
    logic         cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] cfg_data = '0;

    // predictor state
    logic [W-1:0] farey_order = W'(fsg_pkg::MAX_ORDER_RST);
    logic [W-1:0] prev_num = '0;
    logic [W-1:0] prev_den = W'(1);
    logic [W-1:0] cur_num = '0;
    logic [W-1:0] cur_den = W'(1);
    bit           seq_started = 1'b0;

    bit          restart_queue[$];
    t_farey_term expected_terms[$];

    bit in_taken  = 1'b0;
    bit cfg_taken = 1'b0;
    int send_idle_pct = 32;
    int recv_idle_pct = 49;
    int error_count = 0;
    int quiet_cycles = 0;

    farey_sequence_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_last        (o_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void shift_term(int unsigned num, int unsigned den);
        prev_num = cur_num;
        prev_den = cur_den;
        cur_num  = W'(num);
        cur_den  = W'(den);
    endfunction

    // next term of the Farey sequence via the neighbour recurrence
    function automatic t_farey_term next_farey_term(bit restart_req);
        int unsigned n, k, kc, kd, e, f;
        t_farey_term t;
        n = (farey_order == 0) ? 1 : farey_order;
        if (restart_req || !seq_started || cur_den == 0 || cur_num >= cur_den) begin
            prev_num = '0;
            prev_den = W'(1);
            cur_num = '0;
            cur_den = W'(1);
            seq_started = 1'b1;
        end else if (cur_num == 0) begin
            shift_term(1, n);
        end else begin
            k  = (n + prev_den) / cur_den;
            kc = k * cur_num;
            kd = k * cur_den;
            if (kd <= prev_den || kc < prev_num) begin
                shift_term(1, 1);
            end else begin
                e = kc - prev_num;
                f = kd - prev_den;
                // order changed under a running sequence: close it with 1/1
                if (e >= f || f > n)
                    shift_term(1, 1);
                else
                    shift_term(e, f);
            end
        end
        t.num  = cur_num;
        t.den  = cur_den;
        t.last = (cur_num == 1 && cur_den == 1);
        return t;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    // monitor: acceptance, prediction and checking at the rising edge
    always @(posedge i_clk) begin
        t_farey_term want;
        bit any_fire;
        any_fire  = 1'b0;
        in_taken  = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            if (in_valid && o_in_stall === 1'b0) begin
                expected_terms.push_back(next_farey_term(restart));
                in_taken = 1'b1;
                any_fire = 1'b1;
            end
            if (o_out_valid === 1'b1 && !out_stall) begin
                any_fire = 1'b1;
                if (expected_terms.size() == 0) begin
                    report_mismatch("unexpected term, numerator", 0, o_numerator);
                end else begin
                    want = expected_terms.pop_front();
                    if (o_numerator !== want.num)
                        report_mismatch("numerator", want.num, o_numerator);
                    if (o_denominator !== want.den)
                        report_mismatch("denominator", want.den, o_denominator);
                    if (o_last !== want.last)
                        report_mismatch("last", want.last, o_last);
                end
            end
            if (cfg_valid && o_cfg_ready === 1'b1) begin
                farey_order = cfg_data;
                cfg_taken = 1'b1;
                any_fire = 1'b1;
            end
            quiet_cycles = any_fire ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // driver: request channel and receiver stall change at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_taken) begin
                if (restart_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    restart  <= restart_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // check just after the falling edge, once the driver's update has settled
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (restart_queue.size() != 0 || in_valid || expected_terms.size() != 0);
    endtask

    task automatic write_order(logic [W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge i_clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [W-1:0] order_val, int count, int restart_pct);
        wait_drained();
        write_order(order_val);
        for (int i = 0; i < count; i++)
            restart_queue.push_back($urandom_range(99) < restart_pct);
    endtask

    initial begin
        logic [W-1:0] pick;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default order 8; the first request returns 0/1 even without restart
        restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        // order 1, then order 0 (taken as 1): wrap after 1/1
        wait_drained();
        write_order(W'(1));
        restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0};
        wait_drained();
        write_order(W'(0));
        restart_queue = '{1'b0, 1'b0, 1'b0};
        wait_drained();
        write_order(W'(255));
        restart_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        // shrink the order under a running sequence
        wait_drained();
        write_order(W'(2));
        restart_queue = '{1'b0, 1'b0};

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(9))
                0: pick = W'(255);
                1: pick = W'($urandom_range(17, 254));
                2: pick = W'(0);
                default: pick = W'($urandom_range(1, 12));
            endcase
            wait_drained();
            if (p == RAND_PHASES / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 32;
            end else if (p == 2 * RAND_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(pick, PHASE_ITEMS, 4);
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
